### src/cpc_pkg.sv
// Shared types and constants for the capsule pair collision unit.
package cpc_pkg;

  localparam int SLOT_W  = 4;
  localparam int POS_W   = 32;
  localparam int DIR_W   = 16;
  localparam int LEN_W   = 31;
  localparam int DEPTH_W = 63;
  // divider: numerator magnitude (dot product times 2^14) and squared cross product
  localparam int NUM_W   = 96;
  localparam int DEN_W   = 64;

  // operation codes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  typedef logic        [SLOT_W-1:0]  slot_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic        [LEN_W-1:0]   len_t;
  typedef logic        [DEPTH_W-1:0] depth_t;

  // one table entry
  typedef struct packed {
    pos_t px;
    pos_t py;
    pos_t pz;
    dir_t vx;
    dir_t vy;
    dir_t vz;
    len_t reach;
    len_t radius;
  } capsule_t;

endpackage

### src/cpc_if.sv
// Valid/ready channel interfaces for items in and results out.
interface cpc_in_if;
  logic            valid;
  logic            ready;
  logic            operation;
  cpc_pkg::slot_t  slot_a;
  cpc_pkg::slot_t  slot_b;
  cpc_pkg::pos_t   pos_x;
  cpc_pkg::pos_t   pos_y;
  cpc_pkg::pos_t   pos_z;
  cpc_pkg::dir_t   dir_x;
  cpc_pkg::dir_t   dir_y;
  cpc_pkg::dir_t   dir_z;
  cpc_pkg::len_t   reach;
  cpc_pkg::len_t   radius;

  modport source(output valid, operation, slot_a, slot_b, pos_x, pos_y, pos_z,
                 dir_x, dir_y, dir_z, reach, radius, input ready);
  modport sink(input valid, operation, slot_a, slot_b, pos_x, pos_y, pos_z,
               dir_x, dir_y, dir_z, reach, radius, output ready);
endinterface

interface cpc_out_if;
  logic             valid;
  logic             ready;
  logic             hit;
  cpc_pkg::depth_t  depth;
  logic             diff_valid;
  cpc_pkg::pos_t    diff_x;
  cpc_pkg::pos_t    diff_y;
  cpc_pkg::pos_t    diff_z;

  modport source(output valid, hit, depth, diff_valid, diff_x, diff_y, diff_z,
                 input ready);
  modport sink(input valid, hit, depth, diff_valid, diff_x, diff_y, diff_z,
               output ready);
endinterface

### src/capsule_pair_collision_unit.sv
// Capsule table with a pairwise skin-intersection test (top level).
//
// in_ch carries one transaction per store or test. A store writes the capsule
// into slot_a in the cycle it is accepted and gives no result; the next
// transaction can be accepted in the following cycle. A test reads both
// capsules from the table RAM and walks a sequencer over one shared signed
// 34x34 multiplier and a bit-serial divider. A test whose axes are not
// parallel runs the divider and takes longest; parallel axes skip it, and an
// early rejection ends a test sooner; a slot beyond the table gives its
// result in the cycle after accept. The divider dominates. One transaction
// is in flight at a time.
// The result sits in an output register on out_ch; while the receiver
// stalls it holds and no new transaction is accepted.
// Reset returns the sequencer to idle. The table is not cleared: a test of a
// slot never stored gives undefined fields.
module capsule_pair_collision_unit #(
  parameter int CAPSULE_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  cpc_in_if.sink            in_ch,
  cpc_out_if.source         out_ch
);

  localparam int ADDR_W = (CAPSULE_SLOTS > 1) ? $clog2(CAPSULE_SLOTS) : 1;
  localparam int SX_W   = (ADDR_W > cpc_pkg::SLOT_W) ? ADDR_W : cpc_pkg::SLOT_W;
  localparam int CAP_W  = $bits(cpc_pkg::capsule_t);
  localparam int ACC_W  = 84;
  localparam int DIF_W  = 40;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_A, S_RD_B, S_LOAD, S_BND, S_DSQ, S_NX, S_DEN, S_WX, S_NUM,
    S_DVS, S_DIV, S_OFS, S_XSQ, S_RSQ, S_OUT
  } state_t;

  typedef struct packed {
    logic            hit;
    cpc_pkg::depth_t depth;
    logic            dv;
    cpc_pkg::pos_t   dx;
    cpc_pkg::pos_t   dy;
    cpc_pkg::pos_t   dz;
  } res_t;

  state_t                    state_r;
  logic                      ph_r;
  logic [2:0]                k_r;
  logic                      pass_r;
  logic [ADDR_W-1:0]         sa_r, sb_r;
  cpc_pkg::capsule_t         c1_r, c2_r;
  logic signed [32:0]        d_r [3];
  logic signed [32:0]        n_r [3];
  logic signed [48:0]        w_r [3];
  logic signed [DIF_W-1:0]   diff_r [3];
  logic [63:0]               bnd_r;
  logic [65:0]               sum_r;
  logic                      sat_r;
  logic [63:0]               den_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [63:0]        s_r, t_r;
  logic signed [67:0]        mul_r;
  res_t                      res_r;

  function automatic logic [1:0] nx1(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic signed [33:0] sx_dir(input cpc_pkg::dir_t v);
    return {{18{v[15]}}, v};
  endfunction

  function automatic cpc_pkg::pos_t sat32(input logic signed [DIF_W-1:0] v);
    if (v > DIF_W'(signed'(32'sh7fffffff)))       return 32'sh7fffffff;
    else if (v < DIF_W'(signed'(32'sh80000000)))  return 32'sh80000000;
    else                                           return v[31:0];
  endfunction

  // handshakes and table access
  logic              in_fire;
  logic              a_in, b_in;
  logic              ram_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  cpc_pkg::capsule_t wr_cap, rd_cap;
  logic [CAP_W-1:0]  rd_data;
  logic [SX_W-1:0]   slot_a_x, slot_b_x;

  assign slot_a_x    = SX_W'(in_ch.slot_a);
  assign slot_b_x    = SX_W'(in_ch.slot_b);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign a_in        = 32'(in_ch.slot_a) < 32'(CAPSULE_SLOTS);
  assign b_in        = 32'(in_ch.slot_b) < 32'(CAPSULE_SLOTS);
  assign wr_addr     = slot_a_x[ADDR_W-1:0];
  assign ram_we      = in_fire && (in_ch.operation == cpc_pkg::OP_STORE) && a_in;
  assign rd_addr     = (state_r == S_RD_A) ? sa_r : sb_r;
  assign rd_cap      = cpc_pkg::capsule_t'(rd_data);

  always_comb begin
    wr_cap.px     = in_ch.pos_x;
    wr_cap.py     = in_ch.pos_y;
    wr_cap.pz     = in_ch.pos_z;
    wr_cap.vx     = in_ch.dir_x;
    wr_cap.vy     = in_ch.dir_y;
    wr_cap.vz     = in_ch.dir_z;
    wr_cap.reach  = in_ch.reach;
    wr_cap.radius = in_ch.radius;
  end

  cpc_ram #(
    .WIDTH (CAP_W),
    .DEPTH (CAPSULE_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr),
    .wr_data (CAP_W'(wr_cap)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // axis components as arrays
  cpc_pkg::dir_t v1 [3], v2 [3];
  always_comb begin
    v1[0] = c1_r.vx;  v1[1] = c1_r.vy;  v1[2] = c1_r.vz;
    v2[0] = c2_r.vx;  v2[1] = c2_r.vy;  v2[2] = c2_r.vz;
  end

  // step control: i picks the component, term the half of a pair of products
  logic [1:0] ki, kc;
  logic       term;
  logic       is_mul, step_last;
  assign ki   = k_r[2:1];
  assign kc   = k_r[1:0];
  assign term = k_r[0];

  always_comb begin
    is_mul    = 1'b0;
    step_last = 1'b0;
    case (state_r)
      S_BND, S_RSQ: begin
        is_mul = 1'b1;  step_last = 1'b1;
      end
      S_DSQ, S_DEN, S_XSQ: begin
        is_mul = 1'b1;  step_last = (k_r == 3'd2);
      end
      S_NX, S_WX, S_NUM, S_OFS: begin
        is_mul = 1'b1;  step_last = (k_r == 3'd5);
      end
      default: ;
    endcase
  end

  // shared multiplier operand selection
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [67:0] mul_sh;
  logic [31:0]        l_sum, r_sum;
  logic [1:0]         i1, i2;
  cpc_pkg::dir_t      va [3];

  assign l_sum = {1'b0, c1_r.reach}  + {1'b0, c2_r.reach};
  assign r_sum = {1'b0, c1_r.radius} + {1'b0, c2_r.radius};
  assign i1    = nx1(ki);
  assign i2    = nx1(i1);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      va[j] = pass_r ? v1[j] : v2[j];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_BND: begin
        mul_a = {2'b0, l_sum};  mul_b = {2'b0, l_sum};
      end
      S_RSQ: begin
        mul_a = {2'b0, r_sum};  mul_b = {2'b0, r_sum};
      end
      S_DSQ: begin
        mul_a = 34'(d_r[kc]);   mul_b = 34'(d_r[kc]);
      end
      S_DEN: begin
        mul_a = 34'(n_r[kc]);   mul_b = 34'(n_r[kc]);
      end
      S_XSQ: begin
        mul_a = diff_r[kc][33:0];  mul_b = diff_r[kc][33:0];
      end
      S_NX: begin
        mul_a = term ? sx_dir(v1[i2]) : sx_dir(v1[i1]);
        mul_b = term ? sx_dir(v2[i1]) : sx_dir(v2[i2]);
      end
      S_WX: begin
        mul_a = term ? sx_dir(va[i2]) : sx_dir(va[i1]);
        mul_b = term ? 34'(n_r[i1]) : 34'(n_r[i2]);
      end
      S_NUM: begin
        mul_a = 34'(d_r[ki]);
        mul_b = term ? {{9{w_r[ki][48]}}, w_r[ki][48:24]} : {10'b0, w_r[ki][23:0]};
      end
      S_OFS: begin
        mul_a = term ? sx_dir(v1[ki]) : sx_dir(v2[ki]);
        mul_b = term ? s_r[33:0] : t_r[33:0];
      end
      default: ;
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign mul_sh = mul_r >>> 14;

  // accumulations
  logic [65:0]             sum_nxt;
  logic [63:0]             den_nxt;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    comp_sat;

  assign sum_nxt  = sum_r + {2'b0, mul_r[63:0]};
  assign den_nxt  = den_r + mul_r[63:0];
  assign acc_nxt  = term ? acc_r + {mul_r[59:0], 24'b0}
                         : acc_r + {{(ACC_W-68){mul_r[67]}}, mul_r};
  assign comp_sat = (diff_r[kc] > DIF_W'(signed'(33'sh0ffffffff))) ||
                    (diff_r[kc] < -DIF_W'(signed'(33'sh0ffffffff)));

  // divider
  logic [ACC_W-1:0]           acc_mag;
  logic                       div_start, div_done;
  logic [cpc_pkg::NUM_W-1:0]  div_quot;

  assign acc_mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign div_start = (state_r == S_DVS);

  cpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({acc_mag[81:0], 14'b0}),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // saturate the quotient, apply the sign and check it against the span
  logic [62:0]        q_sat;
  logic signed [63:0] sv;
  logic signed [65:0] sv66, rr66, ll66;
  logic               span_bad;

  always_comb begin
    q_sat = (div_quot > cpc_pkg::NUM_W'(64'h4000_0000_0000_0000)) ?
            63'h4000_0000_0000_0000 : div_quot[62:0];
    sv    = acc_r[ACC_W-1] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    sv66  = {{2{sv[63]}}, sv};
    rr66  = {35'b0, (pass_r ? c1_r.radius : c2_r.radius)};
    ll66  = {35'b0, (pass_r ? c2_r.reach : c1_r.reach)};
    span_bad = (sv66 + rr66 < -ll66) || (sv66 - rr66 > ll66);
  end

  // final result from the squared radius sum in mul_r
  res_t        fin_res;
  logic [63:0] dep;
  logic        dist_inf;

  always_comb begin
    dist_inf       = sat_r || (sum_r[65:64] != 2'b00);
    dep            = mul_r[63:0] - sum_r[63:0];
    fin_res.dv     = 1'b1;
    fin_res.dx     = sat32(diff_r[0]);
    fin_res.dy     = sat32(diff_r[1]);
    fin_res.dz     = sat32(diff_r[2]);
    fin_res.hit    = !dist_inf && (sum_r[63:0] < mul_r[63:0]);
    fin_res.depth  = '0;
    if (fin_res.hit) begin
      fin_res.depth = dep[63] ? '1 : dep[62:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= 1'b0;
      k_r     <= '0;
      pass_r  <= 1'b0;
    end else if (is_mul && !ph_r) begin
      mul_r <= mul_p;
      ph_r  <= 1'b1;
    end else begin
      ph_r <= 1'b0;
      if (is_mul) begin
        k_r <= step_last ? 3'd0 : k_r + 3'd1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && (in_ch.operation == cpc_pkg::OP_TEST)) begin
            sa_r <= slot_a_x[ADDR_W-1:0];
            sb_r <= slot_b_x[ADDR_W-1:0];
            if (a_in && b_in) begin
              state_r <= S_RD_A;
            end else begin
              res_r   <= '0;
              state_r <= S_OUT;
            end
          end
        end
        S_RD_A: state_r <= S_RD_B;
        S_RD_B: begin
          c1_r    <= rd_cap;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          c2_r    <= rd_cap;
          d_r[0]  <= {rd_cap.px[31], rd_cap.px} - {c1_r.px[31], c1_r.px};
          d_r[1]  <= {rd_cap.py[31], rd_cap.py} - {c1_r.py[31], c1_r.py};
          d_r[2]  <= {rd_cap.pz[31], rd_cap.pz} - {c1_r.pz[31], c1_r.pz};
          sum_r   <= '0;
          k_r     <= '0;
          state_r <= S_BND;
        end
        S_BND: begin
          bnd_r   <= mul_r[63:0];
          state_r <= S_DSQ;
        end
        S_DSQ: begin
          sum_r <= sum_nxt;
          if (step_last) begin
            if (sum_nxt > {2'b0, bnd_r}) begin
              res_r   <= '0;
              state_r <= S_OUT;
            end else begin
              for (int j = 0; j < 3; j++) n_r[j] <= '0;
              state_r <= S_NX;
            end
          end
        end
        S_NX: begin
          n_r[ki] <= term ? n_r[ki] - mul_r[32:0] : n_r[ki] + mul_r[32:0];
          if (step_last) begin
            den_r   <= '0;
            state_r <= S_DEN;
          end
        end
        S_DEN: begin
          den_r <= den_nxt;
          if (step_last) begin
            if (den_nxt == '0) begin
              s_r <= '0;
              t_r <= '0;
              for (int j = 0; j < 3; j++) diff_r[j] <= DIF_W'(d_r[j]);
              state_r <= S_OFS;
            end else begin
              pass_r <= 1'b0;
              for (int j = 0; j < 3; j++) w_r[j] <= '0;
              state_r <= S_WX;
            end
          end
        end
        S_WX: begin
          w_r[ki] <= term ? w_r[ki] - mul_r[48:0] : w_r[ki] + mul_r[48:0];
          if (step_last) begin
            acc_r   <= '0;
            state_r <= S_NUM;
          end
        end
        S_NUM: begin
          acc_r <= acc_nxt;
          if (step_last) begin
            state_r <= S_DVS;
          end
        end
        S_DVS: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (span_bad) begin
              res_r   <= '0;
              state_r <= S_OUT;
            end else if (!pass_r) begin
              s_r    <= sv;
              pass_r <= 1'b1;
              for (int j = 0; j < 3; j++) w_r[j] <= '0;
              state_r <= S_WX;
            end else begin
              t_r <= sv;
              for (int j = 0; j < 3; j++) diff_r[j] <= DIF_W'(d_r[j]);
              state_r <= S_OFS;
            end
          end
        end
        S_OFS: begin
          diff_r[ki] <= term ? diff_r[ki] - mul_sh[DIF_W-1:0]
                             : diff_r[ki] + mul_sh[DIF_W-1:0];
          if (step_last) begin
            sum_r   <= '0;
            sat_r   <= 1'b0;
            state_r <= S_XSQ;
          end
        end
        S_XSQ: begin
          sum_r <= sum_nxt;
          sat_r <= sat_r | comp_sat;
          if (step_last) begin
            state_r <= S_RSQ;
          end
        end
        S_RSQ: begin
          res_r   <= fin_res;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result channel
  assign out_ch.valid      = (state_r == S_OUT);
  assign out_ch.hit        = res_r.hit;
  assign out_ch.depth      = res_r.depth;
  assign out_ch.diff_valid = res_r.dv;
  assign out_ch.diff_x     = res_r.dx;
  assign out_ch.diff_y     = res_r.dy;
  assign out_ch.diff_z     = res_r.dz;

  // checks
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> $past(state_r) == S_IDLE || state_r == S_IDLE)
    else $error("table written during a test");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input accepted while a result is pending");

  a_reject_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.diff_valid |-> !out_ch.hit && out_ch.depth == '0)
    else $error("rejected test reports a hit or depth");

endmodule

### src/cpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/cpc_div.sv
// Bit-serial restoring divider for the closest-approach quotients.
module cpc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cpc_pkg::NUM_W-1:0]   num,
  input  logic [cpc_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [cpc_pkg::NUM_W-1:0]   quot
);

  localparam int CNT_W = $clog2(cpc_pkg::NUM_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [cpc_pkg::DEN_W-1:0]   den_r;
  logic [cpc_pkg::DEN_W-1:0]   rem_r;
  logic [cpc_pkg::NUM_W-1:0]   q_r;
  logic [cpc_pkg::DEN_W:0]     rem_sh;
  logic                        q_bit;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_r, q_r[cpc_pkg::NUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(cpc_pkg::NUM_W);
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= num;
      end else if (busy_r) begin
        rem_r <= q_bit ? cpc_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                       : rem_sh[cpc_pkg::DEN_W-1:0];
        q_r   <= {q_r[cpc_pkg::NUM_W-2:0], q_bit};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the capsule pair collision unit.
module tb_top;

  localparam int          NSLOTS      = 16;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam logic [63:0] QUOT_SAT    = 64'h4000_0000_0000_0000;
  localparam logic [63:0] U64_MAX     = '1;
  localparam logic [63:0] DEPTH_SAT   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef longint vec3_t [3];

  // one expected or observed result transaction
  typedef struct {
    logic        hit;
    logic [62:0] depth;
    logic        diff_valid;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
  } hit_report_t;

  logic clk;
  logic rst_n;

  cpc_in_if  in_ch();
  cpc_out_if out_ch();

  capsule_pair_collision_unit #(.CAPSULE_SLOTS(NSLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cpc_pkg::capsule_t cap_tbl [NSLOTS];
  hit_report_t       pending_reports [$];
  int                err_count = 0;
  int                cycle_count = 0;
  int                snd_idle_pct;
  int                rcv_idle_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // squared length, saturating at all ones
  function automatic logic [63:0] sq_len(input vec3_t v);
    logic [63:0] sum;
    logic [63:0] m;
    logic [63:0] sq;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      if (m > 64'hFFFF_FFFF) return U64_MAX;
      sq = m * m;
      if (sum > U64_MAX - sq) return U64_MAX;
      sum = sum + sq;
    end
    return sum;
  endfunction

  // (d . w) * 2^14 / den, truncated toward zero, magnitude clamped
  function automatic longint axis_param(input vec3_t d, input vec3_t w,
                                        input logic [63:0] den);
    logic signed [127:0] acc;
    logic signed [127:0] dw;
    logic signed [127:0] ww;
    logic        [127:0] mag;
    logic        [127:0] q;
    logic                neg;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      dw  = 128'(d[i]);
      ww  = 128'(w[i]);
      acc = acc + dw * ww;
    end
    neg = acc[127];
    mag = neg ? 128'(-acc) : 128'(acc);
    mag = mag << 14;
    q   = mag / {64'd0, den};
    if (q > {64'd0, QUOT_SAT}) q = {64'd0, QUOT_SAT};
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic outside_span(input longint s, input longint other_r,
                                        input longint own_reach);
    return (s + other_r < -own_reach) || (s - other_r > own_reach);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic hit_report_t predict_collision(input cpc_pkg::slot_t a,
                                                    input cpc_pkg::slot_t b);
    hit_report_t       r;
    cpc_pkg::capsule_t c1;
    cpc_pkg::capsule_t c2;
    vec3_t             v1, v2, d, n, w, diff;
    longint            s, t, l1, l2, r1, r2;
    logic [63:0]       den, reach_sum, rad_sum, near_dist, bound;
    r  = '{default: '0};
    c1 = cap_tbl[a];
    c2 = cap_tbl[b];
    d[0] = longint'(c2.px) - longint'(c1.px);
    d[1] = longint'(c2.py) - longint'(c1.py);
    d[2] = longint'(c2.pz) - longint'(c1.pz);
    v1[0] = longint'(c1.vx); v1[1] = longint'(c1.vy); v1[2] = longint'(c1.vz);
    v2[0] = longint'(c2.vx); v2[1] = longint'(c2.vy); v2[2] = longint'(c2.vz);
    l1 = longint'({1'b0, c1.reach});
    l2 = longint'({1'b0, c2.reach});
    r1 = longint'({1'b0, c1.radius});
    r2 = longint'({1'b0, c2.radius});
    s  = 0;
    t  = 0;

    // coarse reject on center distance
    reach_sum = 64'(l1) + 64'(l2);
    bound = (reach_sum > 64'hFFFF_FFFF) ? U64_MAX : reach_sum * reach_sum;
    if (sq_len(d) > bound) return r;

    // closest approach on both axis lines, skipped for parallel axes
    cross3(v1, v2, n);
    den = '0;
    for (int i = 0; i < 3; i++) den = den + 64'(n[i] * n[i]);
    if (den != 0) begin
      cross3(v2, n, w);
      s = axis_param(d, w, den);
      if (outside_span(s, r2, l1)) return r;
      cross3(v1, n, w);
      t = axis_param(d, w, den);
      if (outside_span(t, r1, l2)) return r;
    end

    for (int i = 0; i < 3; i++)
      diff[i] = d[i] + ((v2[i] * t) >>> 14) - ((v1[i] * s) >>> 14);
    near_dist = sq_len(diff);
    rad_sum   = 64'(r1) + 64'(r2);
    bound     = (rad_sum > 64'hFFFF_FFFF) ? U64_MAX : rad_sum * rad_sum;

    r.diff_valid = 1'b1;
    r.dx = clamp32(diff[0]);
    r.dy = clamp32(diff[1]);
    r.dz = clamp32(diff[2]);
    if (near_dist < bound) begin
      r.hit   = 1'b1;
      r.depth = ((bound - near_dist) > DEPTH_SAT) ? DEPTH_SAT[62:0]
                                                   : 63'(bound - near_dist);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  // drive one transaction; update the table model or queue a prediction on accept
  task automatic send_item(input logic op, input cpc_pkg::slot_t a,
                           input cpc_pkg::slot_t b, input cpc_pkg::capsule_t cap);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.slot_a    = a;
    in_ch.slot_b    = b;
    in_ch.pos_x     = cap.px;
    in_ch.pos_y     = cap.py;
    in_ch.pos_z     = cap.pz;
    in_ch.dir_x     = cap.vx;
    in_ch.dir_y     = cap.vy;
    in_ch.dir_z     = cap.vz;
    in_ch.reach     = cap.reach;
    in_ch.radius    = cap.radius;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    if (op == cpc_pkg::OP_STORE) begin
      cap_tbl[a] = cap;
    end else begin
      pending_reports.push_back(predict_collision(a, b));
    end
    @(negedge clk);
  endtask

  task automatic store_capsule(input int a, input cpc_pkg::capsule_t cap);
    send_item(cpc_pkg::OP_STORE, cpc_pkg::slot_t'(a),
              cpc_pkg::slot_t'($urandom_range(0, 15)), cap);
  endtask

  // test with random payload bits, which the block ignores on a test
  task automatic test_pair(input int a, input int b);
    cpc_pkg::capsule_t junk;
    junk = cpc_pkg::capsule_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom});
    send_item(cpc_pkg::OP_TEST, cpc_pkg::slot_t'(a), cpc_pkg::slot_t'(b), junk);
  endtask

  // hold the sender until every expected result has come back
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic cpc_pkg::capsule_t make_capsule(input longint px, input longint py,
                                                     input longint pz, input int vx,
                                                     input int vy, input int vz,
                                                     input longint reach,
                                                     input longint radius);
    cpc_pkg::capsule_t c;
    c.px = px[31:0]; c.py = py[31:0]; c.pz = pz[31:0];
    c.vx = vx[15:0]; c.vy = vy[15:0]; c.vz = vz[15:0];
    c.reach  = reach[30:0];
    c.radius = radius[30:0];
    return c;
  endfunction

  // capsule near the origin with a roughly unit axis, so tests get deep
  function automatic cpc_pkg::capsule_t near_capsule();
    cpc_pkg::capsule_t c;
    int       ax;
    int       main_c;
    int       rad;
    logic [15:0] comp [3];
    ax     = $urandom_range(0, 2);
    main_c = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
    for (int i = 0; i < 3; i++)
      comp[i] = (i == ax) ? main_c[15:0] : 16'($signed($urandom_range(0, 12000)) - 6000);
    if ($urandom_range(0, 5) == 0) begin
      comp[0] = 16'd16384; comp[1] = '0; comp[2] = '0;
    end
    c.px = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    c.py = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    c.pz = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    c.vx = comp[0]; c.vy = comp[1]; c.vz = comp[2];
    rad      = $urandom_range(1 << 12, 2 << 16);
    c.radius = 31'(rad);
    c.reach  = 31'(rad + $urandom_range(0, 3 << 16));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------
  // fill every slot with corner and ordinary capsules
  task automatic test_store_table_fill();
    store_capsule(0, make_capsule(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                                  16384, 0, 0, 64'sd2147483647, 64'sd2147483647));
    store_capsule(1, make_capsule(-64'sd2147483648, -64'sd2147483648,
                                  -64'sd2147483648, -16384, -16384, -16384,
                                  64'sd2147483647, 0));
    store_capsule(2, make_capsule(0, 0, 0, 16384, 0, 0, 2 << 16, 1 << 16));
    store_capsule(3, make_capsule(1 << 16, 0, 0, 0, 16384, 0, 2 << 16, 1 << 16));
    store_capsule(4, make_capsule(0, 1 << 15, 0, 16384, 0, 0, 3 << 16, 1 << 16));
    store_capsule(5, make_capsule(0, 0, 40 << 16, 0, 0, 16384, 1 << 16, 1 << 15));
    store_capsule(6, make_capsule(0, 0, 3 << 16, 0, 16384, 0, 9 << 16, 1 << 12));
    store_capsule(7, make_capsule(100 << 16, 0, 0, 0, 0, -16384, 0, 0));
    store_capsule(8, make_capsule(0, 0, 0, -32768, 32767, -32768,
                                  64'sd2147483647, 64'sd2147483647));
    for (int i = 9; i < NSLOTS; i++) store_capsule(i, near_capsule());
  endtask

  task automatic test_extreme_pairs();
    test_pair(0, 1);    // far apart, squared distance saturates
    test_pair(0, 0);    // self test, parallel axes, depth saturates
    test_pair(1, 1);    // zero radius self test
    test_pair(2, 3);    // crossing axes, hit
    test_pair(2, 4);    // parallel axes, offset
    test_pair(2, 5);    // early reject on distance
    test_pair(6, 2);    // skew axes, closest approach inside span, miss
    test_pair(7, 7);    // zero reach and radius
    test_pair(8, 8);    // out-of-range axis
    test_pair(8, 2);
    test_pair(15, 0);
    test_pair(9, 10);
  endtask

  // mostly clustered capsules and tests, some raw noise stores
  task automatic test_random_pairs(input int n_items, input int s_pct, input int r_pct);
    cpc_pkg::capsule_t c;
    snd_idle_pct = s_pct;
    rcv_idle_pct = r_pct;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) drain_results();
      case ($urandom_range(0, 9))
        0: begin
          c = cpc_pkg::capsule_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom});
          store_capsule(int'($urandom_range(0, 15)), c);
        end
        1, 2, 3: store_capsule(int'($urandom_range(0, 15)), near_capsule());
        default: test_pair(int'($urandom_range(0, 15)), int'($urandom_range(0, 15)));
      endcase
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hit_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        err_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.hit !== want.hit) begin
          $display("%0t: hit exp %0d got %0d", $time, want.hit, out_ch.hit);
          err_count++;
        end
        if (out_ch.depth !== want.depth) begin
          $display("%0t: depth exp %h got %h", $time, want.depth, out_ch.depth);
          err_count++;
        end
        if (out_ch.diff_valid !== want.diff_valid) begin
          $display("%0t: diff_valid exp %0d got %0d", $time, want.diff_valid,
                   out_ch.diff_valid);
          err_count++;
        end
        if (out_ch.diff_x !== want.dx) begin
          $display("%0t: diff_x exp %h got %h", $time, want.dx, out_ch.diff_x);
          err_count++;
        end
        if (out_ch.diff_y !== want.dy) begin
          $display("%0t: diff_y exp %h got %h", $time, want.dy, out_ch.diff_y);
          err_count++;
        end
        if (out_ch.diff_z !== want.dz) begin
          $display("%0t: diff_z exp %h got %h", $time, want.dz, out_ch.diff_z);
          err_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // run timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    snd_idle_pct    = 0;
    rcv_idle_pct    = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = cpc_pkg::OP_STORE;
    in_ch.slot_a    = '0;
    in_ch.slot_b    = '0;
    in_ch.pos_x     = '0;
    in_ch.pos_y     = '0;
    in_ch.pos_z     = '0;
    in_ch.dir_x     = '0;
    in_ch.dir_y     = '0;
    in_ch.dir_z     = '0;
    in_ch.reach     = '0;
    in_ch.radius    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    snd_idle_pct = 27;
    rcv_idle_pct = 51;
    test_store_table_fill();
    test_extreme_pairs();
    drain_results();
    test_random_pairs(330, 27, 51);
    test_random_pairs(330, 51, 27);
    test_random_pairs(340, 0, 0);

    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
